// ===== sv/vfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// vfrm_pkg
// shared types and constants of the voxel face run mesher
// ----------------------------------------------------------------------------
package vfrm_pkg;

    localparam int GRID_DIM = 64;

    localparam logic [2:0] FACE_NZ = 3'd0;
    localparam logic [2:0] FACE_PZ = 3'd1;
    localparam logic [2:0] FACE_NY = 3'd2;
    localparam logic [2:0] FACE_PX = 3'd3;
    localparam logic [2:0] FACE_PY = 3'd4;
    localparam logic [2:0] FACE_NX = 3'd5;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CELL_RD,
        S_CELL_WAIT,
        S_NB_WAIT,
        S_RUN_RD,
        S_RUN_WAIT,
        S_RUN_NB_WAIT,
        S_EMIT,
        S_END
    } t_state;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] face;
        logic [5:0] x;
        logic [5:0] y;
        logic [5:0] z;
        logic [6:0] len;
        logic [7:0] color;
        logic       last;
    } t_quad;

endpackage

// ===== sv/vfrm_store.sv =====
// ----------------------------------------------------------------------------
// vfrm_store
// single port voxel memory, registered read
// ----------------------------------------------------------------------------
module vfrm_store #(
    parameter int AW = 18
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [(2**AW)-1:0];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/voxel_face_run_mesher_top.sv =====
// ----------------------------------------------------------------------------
// voxel_face_run_mesher_top
// one dimensional greedy face mesher over a voxel store
// ----------------------------------------------------------------------------
// After reset the store is cleared one cell a cycle, all GRID_DIM^3 cells, while
// no transaction is accepted. Transactions are accepted only while the block is idle.
// A write leaves the block idle. A scan reads each visited cell and its neighbour
// through the single store port, two registered reads per cell visited (cells of a
// run and, on X faces, the y run cells). Each quad is held until the next one is found
// or the scan ends, so that the last flag can be set on it, and a new quad waits while
// the held one has not been taken.
module voxel_face_run_mesher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [5:0] i_cell_x,
    input  logic [5:0] i_cell_y,
    input  logic [5:0] i_cell_z,
    input  logic [7:0] i_color,
    input  logic [2:0] i_face,
    input  logic [6:0] i_x_end,
    input  logic [6:0] i_y_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_valid_res,
    output logic [2:0] o_quad_face,
    output logic [5:0] o_quad_x,
    output logic [5:0] o_quad_y,
    output logic [5:0] o_quad_z,
    output logic [6:0] o_run_length,
    output logic [7:0] o_quad_color,
    output logic       o_last
);
    import vfrm_pkg::*;

    localparam int CW = $clog2(GRID_DIM);
    localparam int AW = 3 * CW;
    localparam int KW = CW + 2;

    t_state r_state, n_state;
    logic [6:0] r_sx, r_sy, r_sz;
    logic [AW-1:0] r_clr, n_clr;
    logic [KW-1:0] r_x, n_x, r_y0, n_y0, r_z0, n_z0, r_xe, n_xe, r_ye, n_ye;
    logic [KW-1:0] r_w, n_w;
    logic [2:0] r_f, n_f;
    logic [7:0] r_c, n_c;
    logic [6:0] r_n, n_n;
    logic r_xf, n_xf;
    t_quad r_out, n_out;
    logic r_ov, n_ov;

    logic we;
    logic [AW-1:0] addr;
    logic [7:0] wdata, rdata;

    vfrm_store #(.AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    // coordinates of the cell currently probed (run position)
    logic [KW-1:0] px, py;
    logic [KW+1:0] bx, by, bz;
    logic nb_in, nb_store, p_in;

    always_comb begin
        px = r_xf ? r_x : r_x + r_w;
        py = r_xf ? r_y0 + r_w : r_y0;
        bx = {2'b0, px};
        by = {2'b0, py};
        bz = {2'b0, r_z0};
        unique case (r_f)
            FACE_NZ: bz = bz - 1'b1;
            FACE_PZ: bz = bz + 1'b1;
            FACE_NY: by = by - 1'b1;
            FACE_PX: bx = bx + 1'b1;
            FACE_PY: by = by + 1'b1;
            default: bx = bx - 1'b1;
        endcase
        nb_in = !bx[KW+1] && !by[KW+1] && !bz[KW+1]
            && (bx < {{(KW-5){1'b0}}, r_sx}) && (by < {{(KW-5){1'b0}}, r_sy})
            && (bz < {{(KW-5){1'b0}}, r_sz});
        nb_store = (bx < GRID_DIM) && (by < GRID_DIM) && (bz < GRID_DIM);
        p_in = (px < GRID_DIM) && (py < GRID_DIM) && (r_z0 < GRID_DIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= 7'd64;
            r_sy <= 7'd64;
            r_sz <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_sx <= i_cfg_data;
                CFG_SIZE_Y: r_sy <= i_cfg_data;
                CFG_SIZE_Z: r_sz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
        r_x <= n_x; r_y0 <= n_y0; r_z0 <= n_z0; r_xe <= n_xe; r_ye <= n_ye;
        r_w <= n_w; r_f <= n_f; r_c <= n_c; r_n <= n_n; r_xf <= n_xf;
        r_out <= n_out;
    end

    logic can_out, out_fire;
    logic [KW:0] lim_x, lim_y;
    assign out_fire = o_valid && i_ready;
    assign can_out = !r_ov || out_fire;

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_x = r_x; n_y0 = r_y0; n_z0 = r_z0; n_xe = r_xe; n_ye = r_ye;
        n_w = r_w; n_f = r_f; n_c = r_c; n_n = r_n; n_xf = r_xf;
        n_out = r_out;
        n_ov = r_ov && !out_fire;
        we = 1'b0;
        wdata = i_color;
        addr = {r_z0[CW-1:0], py[CW-1:0], px[CW-1:0]};
        o_ready = 1'b0;
        lim_x = {1'b0, r_x} + {1'b0, r_w};
        lim_y = {1'b0, r_y0} + {1'b0, r_w};
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wdata = '0;
                addr = r_clr;
                n_clr = r_clr + 1'b1;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                addr = {i_cell_z[CW-1:0], i_cell_y[CW-1:0], i_cell_x[CW-1:0]};
                if (i_valid) begin
                    if (i_kind == KIND_WRITE) begin
                        we = (i_cell_x < GRID_DIM) && (i_cell_y < GRID_DIM)
                            && (i_cell_z < GRID_DIM);
                    end else begin
                        n_x = KW'(i_cell_x); n_y0 = KW'(i_cell_y); n_z0 = KW'(i_cell_z);
                        n_xe = (i_x_end > GRID_DIM) ? KW'(GRID_DIM) : KW'(i_x_end);
                        n_ye = (i_y_end > GRID_DIM) ? KW'(GRID_DIM) : KW'(i_y_end);
                        n_f = i_face; n_n = '0; n_w = '0;
                        n_xf = (i_face == FACE_PX) || (i_face == FACE_NX);
                        n_state = (i_face > FACE_NX) ? S_END : S_CELL_RD;
                    end
                end
            end
            S_CELL_RD: begin
                // cell at r_x, r_w is 0
                if (r_x >= r_xe || r_n == 7'd64) n_state = S_END;
                else n_state = S_CELL_WAIT;
            end
            S_CELL_WAIT: begin
                n_c = p_in ? rdata : 8'd0;
                addr = {bz[CW-1:0], by[CW-1:0], bx[CW-1:0]};
                n_state = S_NB_WAIT;
            end
            S_NB_WAIT: begin
                if (r_c == 8'd0 || (nb_in && nb_store && rdata != 8'd0)) begin
                    n_x = r_x + 1'b1;
                    n_state = S_CELL_RD;
                end else begin
                    n_w = KW'(1);
                    n_state = S_RUN_RD;
                end
            end
            S_RUN_RD: begin
                if (r_xf ? (lim_y >= {1'b0, r_ye}) : (lim_x >= {1'b0, r_xe}))
                    n_state = S_EMIT;
                else n_state = S_RUN_WAIT;
            end
            S_RUN_WAIT: begin
                addr = {bz[CW-1:0], by[CW-1:0], bx[CW-1:0]};
                if (!p_in || rdata != r_c) n_state = S_EMIT;
                else n_state = S_RUN_NB_WAIT;
            end
            S_RUN_NB_WAIT: begin
                if (nb_in && nb_store && rdata != 8'd0) n_state = S_EMIT;
                else begin
                    n_w = r_w + 1'b1;
                    n_state = S_RUN_RD;
                end
            end
            S_EMIT: begin
                if (can_out) begin
                    n_ov = 1'b1;
                    n_out = '{1'b1, r_f, r_x[5:0], r_y0[5:0], r_z0[5:0],
                              7'(r_w), r_c, 1'b0};
                    n_n = r_n + 1'b1;
                    n_x = r_xf ? r_x + 1'b1 : r_x + r_w;
                    n_w = '0;
                    n_state = S_CELL_RD;
                end
            end
            S_END: begin
                // final marker, or last flag on the held quad
                if (r_n != '0) begin
                    n_out.last = 1'b1;
                    n_state = S_IDLE;
                end else if (can_out) begin
                    n_ov = 1'b1;
                    n_out = '{1'b0, 3'd0, 6'd0, 6'd0, 6'd0, 7'd0, 8'd0, 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a held quad is offered once the next one replaces it or it is marked last
    assign o_valid      = r_ov && (r_out.last || r_state == S_EMIT);
    assign o_valid_res  = r_out.valid_res;
    assign o_quad_face  = r_out.face;
    assign o_quad_x     = r_out.x;
    assign o_quad_y     = r_out.y;
    assign o_quad_z     = r_out.z;
    assign o_run_length = r_out.len;
    assign o_quad_color = r_out.color;
    assign o_last       = r_out.last;
endmodule

// ===== test/voxel_face_run_mesher_checker.sv =====
// ----------------------------------------------------------------------------
// voxel_face_run_mesher_checker
// watches both channels, predicts the quads of every scan and compares them
// ----------------------------------------------------------------------------
module voxel_face_run_mesher_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [6:0]      i_cfg_data,
    input  logic            i_valid,
    input  logic            i_ready_in,
    input  logic            i_kind,
    input  logic [5:0]      i_cell_x,
    input  logic [5:0]      i_cell_y,
    input  logic [5:0]      i_cell_z,
    input  logic [7:0]      i_color,
    input  logic [2:0]      i_face,
    input  logic [6:0]      i_x_end,
    input  logic [6:0]      i_y_end,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  vfrm_pkg::t_quad i_quad,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_quad_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vfrm_pkg::*;

    logic [7:0] cells [int];
    logic [6:0] ext_x, ext_y, ext_z;
    t_quad      quad_queue[$];

    function automatic logic [7:0] cell_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x > 63 || y > 63 || z > 63) return 8'd0;
        if (!cells.exists(x + y * 64 + z * 4096)) return 8'd0;
        return cells[x + y * 64 + z * 4096];
    endfunction

    function automatic bit face_open(int x, int y, int z, logic [2:0] f);
        int nx, ny, nz;
        nx = x; ny = y; nz = z;
        case (f)
            FACE_NZ: nz = z - 1;
            FACE_PZ: nz = z + 1;
            FACE_NY: ny = y - 1;
            FACE_PX: nx = x + 1;
            FACE_PY: ny = y + 1;
            default: nx = x - 1;
        endcase
        if (nx >= 0 && nx < ext_x && ny >= 0 && ny < ext_y && nz >= 0 && nz < ext_z)
            return cell_at(nx, ny, nz) == 8'd0;
        return 1'b1;
    endfunction

    task automatic mesh_row(input logic [5:0] cx, input logic [5:0] cy, input logic [5:0] cz,
                            input logic [2:0] f, input logic [6:0] xe_in,
                            input logic [6:0] ye_in);
        int xe, ye, n, w, x;
        bit xface;
        logic [7:0] c;
        t_quad q;
        xe = (xe_in > 64) ? 64 : xe_in;
        ye = (ye_in > 64) ? 64 : ye_in;
        n = 0;
        xface = (f == FACE_PX || f == FACE_NX);
        if (f <= FACE_NX) begin
            x = cx;
            while (x < xe && n < 64) begin
                c = cell_at(x, cy, cz);
                w = 1;
                if (c != 0 && face_open(x, cy, cz, f)) begin
                    if (!xface) begin
                        while (x + w < xe && cell_at(x + w, cy, cz) == c &&
                               face_open(x + w, cy, cz, f)) w++;
                    end else begin
                        while (cy + w < ye && cell_at(x, cy + w, cz) == c &&
                               face_open(x, cy + w, cz, f)) w++;
                    end
                    q = '{1'b1, f, 6'(x), cy, cz, 7'(w), c, 1'b0};
                    quad_queue.insert(quad_queue.size(), q);
                    n++;
                    if (!xface) x += w - 1;
                end
                x++;
            end
        end
        if (n == 0) begin
            q = '0;
            quad_queue.insert(quad_queue.size(), q);
        end
        quad_queue[quad_queue.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_quad e;
        if (!i_rst_n) begin
            cells.delete();
            quad_queue.delete();
            ext_x <= 7'd64; ext_y <= 7'd64; ext_z <= 7'd64;
            o_fail_count <= 0;
            o_quad_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE_X: ext_x <= i_cfg_data;
                    CFG_SIZE_Y: ext_y <= i_cfg_data;
                    CFG_SIZE_Z: ext_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_quad_count <= o_quad_count + 1;
                if (quad_queue.size() == 0) begin
                    $display("%0t unexpected result: got %p", $time, i_quad);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = quad_queue.pop_front();
                    if (e !== i_quad) begin
                        $display("%0t result mismatch: expected %p actual %p",
                                 $time, e, i_quad);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                if (i_kind == KIND_WRITE)
                    cells[i_cell_x + i_cell_y * 64 + i_cell_z * 4096] = i_color;
                else
                    mesh_row(i_cell_x, i_cell_y, i_cell_z, i_face, i_x_end, i_y_end);
            end
            o_pending <= quad_queue.size();
        end
    end
endmodule

// ===== test/voxel_face_run_mesher_top_test.sv =====
// ----------------------------------------------------------------------------
// voxel_face_run_mesher_top_test
// builds small voxel scenes by writes, scans rows on every face and checks quads
// ----------------------------------------------------------------------------
module voxel_face_run_mesher_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vfrm_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_SIZE_X;
    logic [6:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_kind = KIND_WRITE;
    logic [5:0] i_cell_x = '0, i_cell_y = '0, i_cell_z = '0;
    logic [7:0] i_color = '0;
    logic [2:0] i_face = FACE_NZ;
    logic [6:0] i_x_end = 7'd1, i_y_end = 7'd1;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_valid_res;
    logic [2:0] o_quad_face;
    logic [5:0] o_quad_x, o_quad_y, o_quad_z;
    logic [6:0] o_run_length;
    logic [7:0] o_quad_color;
    logic       o_last;
    t_quad      out_quad;
    int         fail_count, pending, quad_count;
    int         item_count, scan_count;
    bit         stall_free;

    voxel_face_run_mesher_top DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid, .o_ready,
        .i_kind, .i_cell_x, .i_cell_y, .i_cell_z, .i_color, .i_face, .i_x_end, .i_y_end,
        .o_valid, .i_ready,
        .o_valid_res, .o_quad_face, .o_quad_x, .o_quad_y, .o_quad_z,
        .o_run_length, .o_quad_color, .o_last
    );

    assign out_quad = {o_valid_res, o_quad_face, o_quad_x, o_quad_y, o_quad_z,
                       o_run_length, o_quad_color, o_last};

    voxel_face_run_mesher_checker checker_u (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid,
        .i_ready_in(o_ready), .i_kind, .i_cell_x, .i_cell_y, .i_cell_z, .i_color, .i_face,
        .i_x_end, .i_y_end, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_quad(out_quad), .o_fail_count(fail_count), .o_pending(pending),
        .o_quad_count(quad_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stall pattern, with stretches of no stalls
    always @(posedge i_clk) begin
        if (stall_free) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(input logic k, input int x, input int y, input int z,
                        input int c, input int f, input int xe, input int ye);
        if ($urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= k;
        i_cell_x <= 6'(x); i_cell_y <= 6'(y); i_cell_z <= 6'(z);
        i_color <= 8'(c); i_face <= 3'(f);
        i_x_end <= 7'(xe); i_y_end <= 7'(ye);
        do @(posedge i_clk); while (!o_ready);
        item_count++;
        if (k == KIND_SCAN) scan_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [1:0] idx, input int v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 7'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_cell(input int x, input int y, input int z, input int c);
        send(KIND_WRITE, x, y, z, c, FACE_NZ, 1, 1);
    endtask

    task automatic scan_row(input int x, input int y, input int z, input int f,
                            input int xe, input int ye);
        send(KIND_SCAN, x, y, z, $urandom_range(0, 255), f, xe, ye);
    endtask

    // random scene in a small box near the origin or the far corner, with scans across it
    task automatic random_phase(input int n_items);
        int base, k, lim;
        base = $urandom_range(0, 1) ? 0 : 58;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                k = $urandom_range(0, 9);
                write_cell(base + $urandom_range(0, 5), base + $urandom_range(0, 5),
                           base + $urandom_range(0, 5),
                           k < 3 ? 0 : (k < 8 ? $urandom_range(1, 2) : $urandom_range(0, 255)));
            end else begin
                lim = $urandom_range(0, 9) == 0 ? 64 : base + $urandom_range(0, 7);
                scan_row($urandom_range(0, 7) == 0 ? $urandom_range(0, 63)
                                                   : base + $urandom_range(0, 5),
                         base + $urandom_range(0, 5), base + $urandom_range(0, 5),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                   : $urandom_range(0, 5),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) : lim,
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                   : base + $urandom_range(0, 7));
            end
        end
    endtask

    initial begin
        stall_free = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: runs, gaps, both corners, every face, bad faces and odd ends
        write_cell(0, 0, 0, 255);
        write_cell(1, 0, 0, 255);
        write_cell(2, 0, 0, 255);
        write_cell(4, 0, 0, 7);
        write_cell(0, 1, 0, 255);
        write_cell(63, 63, 63, 170);
        write_cell(62, 63, 63, 85);
        write_cell(1, 0, 0, 0);
        for (int f = 0; f < 8; f++) scan_row(0, 0, 0, f, 64, 64);
        scan_row(60, 63, 63, FACE_PX, 127, 127);
        scan_row(60, 63, 63, FACE_PZ, 64, 64);
        scan_row(5, 0, 0, FACE_NZ, 3, 64);
        scan_row(0, 0, 0, FACE_NX, 8, 0);
        scan_row(0, 63, 63, FACE_PY, 64, 64);
        drain();

        // zero, minimum and oversized sizes make every neighbour outside
        set_size(CFG_SIZE_X, 0);
        set_size(CFG_SIZE_Y, 1);
        set_size(CFG_SIZE_Z, 127);
        stall_free = 1'b1;
        for (int f = 0; f < 6; f++) scan_row(0, 0, 0, f, 64, 64);
        drain();
        stall_free = 1'b0;

        set_size(CFG_SIZE_X, 64);
        set_size(CFG_SIZE_Y, 64);
        set_size(CFG_SIZE_Z, 64);
        random_phase(110);
        drain();

        set_size(CFG_SIZE_X, 3);
        set_size(CFG_SIZE_Y, 60);
        set_size(CFG_SIZE_Z, 1);
        random_phase(100);
        drain();

        set_size(CFG_SIZE_X, 64);
        set_size(CFG_SIZE_Y, 62);
        set_size(CFG_SIZE_Z, 61);
        random_phase(100);
        drain();

        $display("sent %0d transactions, %0d scans, %0d results checked",
                 item_count, scan_count, quad_count);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/vfrm_pkg.sv
sv/vfrm_store.sv
sv/voxel_face_run_mesher_top.sv
test/voxel_face_run_mesher_checker.sv
test/voxel_face_run_mesher_top_test.sv
